// ===== src/u16u8_pkg.sv =====
// shared types and constants for the utf-16le to utf-8 converter
package u16u8_pkg;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_beat_t;

    typedef enum logic [3:0] {
        PH_LOW  = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_CR   = 4'b0100,
        PH_CRLF = 4'b1000
    } phase_t;

endpackage

// ===== src/utf16le_to_utf8_converter_unit.sv =====
// utf-16le byte stream to utf-8 byte stream converter
// path: an accepted input beat is held in the input register and advances into the run
//   register, which drives the output; a stalled output run holds it in the input register
// throughput: while out_ready is high, one output beat per cycle, and one input beat per cycle
//   while no byte gives more than one output byte; a high byte giving two or three bytes
//   stalls input until its run is down to its last byte
// reset: asynchronous, active low; clears phase, held byte and all valid state
module utf16le_to_utf8_converter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u16u8_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u16u8_pkg::out_beat_t out_data
);

    logic                in_vld_reg;
    u16u8_pkg::in_beat_t in_beat_reg;

    u16u8_pkg::phase_t phase_reg;
    u16u8_pkg::phase_t phase_next;
    logic [7:0]        held_reg;
    logic [7:0]        held_next;

    logic [1:0] run_cnt_reg;
    logic [1:0] run_cnt_next;
    logic [7:0] run_b0_reg;
    logic [7:0] run_b1_reg;
    logic [7:0] run_b2_reg;

    logic [1:0]  new_cnt;
    logic [7:0]  new_b0;
    logic [7:0]  new_b1;
    logic [7:0]  new_b2;
    logic [15:0] unit_val;
    logic [7:0]  cur_byte;
    logic        advance;
    logic        out_take;

    assign out_take  = out_valid && out_ready;
    assign advance   = in_vld_reg && ((run_cnt_reg == 2'd0) ||
                                      ((run_cnt_reg == 2'd1) && out_ready));
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = (run_cnt_reg != 2'd0);
    assign out_data.out_byte    = run_b0_reg;
    assign out_data.last_of_run = (run_cnt_reg == 2'd1);

    assign cur_byte = in_beat_reg.in_byte;
    assign unit_val = {cur_byte, held_reg};

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        new_cnt    = 2'd0;
        new_b0     = cur_byte;
        new_b1     = 8'h00;
        new_b2     = 8'h00;
        unique case (phase_reg)
            u16u8_pkg::PH_HIGH:
            begin
                phase_next = u16u8_pkg::PH_LOW;
                priority if (unit_val[15:7] == 9'd0)
                begin
                    new_cnt = 2'd1;
                    new_b0  = {1'b0, unit_val[6:0]};
                end
                else if (unit_val[15:11] == 5'd0)
                begin
                    new_cnt = 2'd2;
                    new_b0  = {3'b110, unit_val[10:6]};
                    new_b1  = {2'b10, unit_val[5:0]};
                end
                else
                begin
                    new_cnt = 2'd3;
                    new_b0  = {4'b1110, unit_val[15:12]};
                    new_b1  = {2'b10, unit_val[11:6]};
                    new_b2  = {2'b10, unit_val[5:0]};
                end
            end
            u16u8_pkg::PH_LOW,
            u16u8_pkg::PH_CR,
            u16u8_pkg::PH_CRLF:
            begin
                priority if ((phase_reg == u16u8_pkg::PH_CR) &&
                             (cur_byte == u16u8_pkg::LF_BYTE))
                begin
                    new_cnt    = 2'd1;
                    phase_next = u16u8_pkg::PH_CRLF;
                end
                else if ((phase_reg == u16u8_pkg::PH_CRLF) &&
                         (cur_byte == u16u8_pkg::NUL_BYTE))
                begin
                    phase_next = u16u8_pkg::PH_LOW;
                end
                else if (cur_byte == u16u8_pkg::CR_BYTE)
                begin
                    new_cnt    = 2'd1;
                    phase_next = u16u8_pkg::PH_CR;
                end
                else
                begin
                    held_next  = cur_byte;
                    phase_next = u16u8_pkg::PH_HIGH;
                end
            end
            default:
            begin
                phase_next = u16u8_pkg::PH_LOW;
            end
        endcase
        if (in_beat_reg.end_of_text)
        begin
            phase_next = u16u8_pkg::PH_LOW;
            held_next  = 8'h00;
        end
    end

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (advance)
            run_cnt_next = new_cnt;
        else if (out_take)
            run_cnt_next = run_cnt_reg - 2'd1;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_beat_reg <= in_data;
    end

    // conversion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= u16u8_pkg::PH_LOW;
            held_reg  <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // run register, shifts one byte per output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cnt_reg <= 2'd0;
        else
            run_cnt_reg <= run_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            run_b0_reg <= new_b0;
            run_b1_reg <= new_b1;
            run_b2_reg <= new_b2;
        end
        else if (out_take)
        begin
            run_b0_reg <= run_b1_reg;
            run_b1_reg <= run_b2_reg;
        end
    end

endmodule

// ===== src/u16u8_checker.sv =====
// port-level checker for the utf-16le to utf-8 converter, with its bind
module u16u8_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input u16u8_pkg::in_beat_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input u16u8_pkg::out_beat_t out_data
);

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // a byte that is not last in its run is a lead or continuation byte
    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |->
            out_data.out_byte[7:6] == 2'b11 || out_data.out_byte[7:6] == 2'b10)
        else $error("non-final byte of a run is not multibyte");

    // a final byte with the top bit set closes a multibyte sequence
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_of_run && out_data.out_byte[7] |->
            out_data.out_byte[6] == 1'b0)
        else $error("run ends on a lead byte");

    // the rest of a run follows without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("gap inside an output run");

endmodule

bind utf16le_to_utf8_converter_unit u16u8_checker u_u16u8_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
